FILE: design/scalar_kalman_filter_core_assert.svh
// assertion macros shared by the checker of the scalar kalman filter core
// no dependencies
`ifndef SCALAR_KALMAN_FILTER_CORE_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_CORE_ASSERT_SVH

// checked only while out of reset
`define SKF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SKF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/skf_pkg.sv
// types and constants of the scalar kalman filter core
// no dependencies; used by the core, the divider and the checker
`default_nettype none

package skf_pkg;

    typedef struct packed {
        logic               op;
        logic signed [31:0] measurement;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] estimate;
        logic signed [31:0] gain;
        logic               saturated;
    } t_out_item;

    // status of the gain divider towards the sequencer
    typedef struct packed {
        logic               done;
        logic               clip;
        logic signed [31:0] quot;
    } t_div_res;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REINIT = 1'b1;

    localparam logic [2:0] REG_PROCESS_NOISE = 3'd0;
    localparam logic [2:0] REG_MEASURE_NOISE = 3'd1;
    localparam logic [2:0] REG_STATE_GAIN    = 3'd2;
    localparam logic [2:0] REG_OBSERVE_GAIN  = 3'd3;
    localparam logic [2:0] REG_INIT_ESTIMATE = 3'd4;
    localparam logic [2:0] REG_INIT_VARIANCE = 3'd5;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

FILE: design/skf_divider.sv
// bit-serial restoring divider for the kalman gain: (num << FRAC_BITS) / den,
// truncated toward zero and saturated to 32 bits; depends on skf_pkg
`default_nettype none

module skf_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic [30:0]        i_den,
    output skf_pkg::t_div_res  o_res
);
    import skf_pkg::*;

    localparam int QW      = 33;
    localparam int LO_KEEP = QW - FRAC_BITS;
    localparam int HI_W    = 63 - LO_KEEP;
    localparam int CNT_W   = $clog2(QW);

    typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_DONE} t_dstate;

    t_dstate            r_state;
    logic [HI_W-1:0]    r_hi;
    logic [QW-1:0]      r_lo;
    logic [30:0]        r_rem;
    logic [30:0]        r_den;
    logic               r_neg;
    logic               r_over;
    logic [CNT_W-1:0]   r_cnt;

    logic [62:0]        mag;
    logic [31:0]        trial;
    logic               trial_ge;
    logic               q_big;
    logic               clip;

    assign mag      = i_num[63] ? 63'(-i_num) : i_num[62:0];
    assign trial    = {r_rem, r_lo[QW-1]};
    assign trial_ge = trial >= {1'b0, r_den};

    // once the bits above the quotient are below den, 33 quotient bits remain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_hi    <= mag[62:LO_KEEP];
                        r_lo    <= {mag[LO_KEEP-1:0], FRAC_BITS'(0)};
                        r_den   <= i_den;
                        r_neg   <= i_num[63];
                        r_state <= D_CHK;
                    end
                end
                D_CHK: begin
                    if (r_hi >= HI_W'(r_den)) begin
                        r_over  <= 1'b1;
                        r_state <= D_DONE;
                    end else begin
                        r_over  <= 1'b0;
                        r_rem   <= r_hi[30:0];
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= trial_ge ? 31'(trial - {1'b0, r_den}) : trial[30:0];
                    r_lo  <= {r_lo[QW-2:0], trial_ge};
                    if (r_cnt == CNT_W'(QW - 1)) begin
                        r_state <= D_DONE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                D_DONE: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    // negative quotients may reach one step further than positive ones
    assign q_big = r_neg ? (r_lo > 33'h0_8000_0000) : (r_lo > 33'h0_7fff_ffff);
    assign clip  = r_over | q_big;

    always_comb begin
        o_res.done = (r_state == D_DONE);
        o_res.clip = clip;
        if (clip) begin
            o_res.quot = r_neg ? S32_MIN : S32_MAX;
        end else begin
            o_res.quot = r_neg ? -$signed(r_lo[31:0]) : $signed(r_lo[31:0]);
        end
    end

endmodule

`default_nettype wire

FILE: design/scalar_kalman_filter_core.sv
// scalar kalman filter core: sequencer, shared multiplier and register file
// depends on skf_pkg and skf_divider
//
// one-dimensional kalman filter in signed fixed point with FRAC_BITS fraction bits.
// requests come in on i_in_valid / o_in_ready with an op and a measurement z;
// op sample runs predict, gain and joseph-form update, op reinit reloads the
// estimate and variance from the init registers and clears the gain.
// each request gives one result on o_out_valid / i_out_ready: new estimate,
// gain used, and a flag set when a value clipped, save a variance clamped at zero.
// o_in_ready is high only while the sequencer is idle, so one request is in
// flight at a time. the single 32x32 multiplier serves 12 products and the gain
// numerator in turn, and the gain comes from the 33-step bit-serial divider.
// a finished result sits in the output register; the next request may be
// accepted meanwhile, but its result waits until the held one is taken.
// configuration is to be written over the apb port only while idle; the user must
// keep to this, as the core does not enforce it. synchronous reset restores the
// register defaults, estimate 0, variance 1.0 and gain 0.
`default_nettype none

module scalar_kalman_filter_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  skf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output skf_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import skf_pkg::*;

    localparam int FX_W = 64 - FRAC_BITS;
    localparam logic signed [31:0] ONE_FX  = 32'(1) << FRAC_BITS;
    localparam logic [30:0]        ONE_VAR = 31'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_POST, S_DIV_GO, S_DIV_WAIT, S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        ST_X1, ST_AP, ST_P1, ST_HP, ST_S, ST_PH, ST_INNOV,
        ST_XN, ST_C, ST_CC, ST_T1, ST_KK, ST_T2
    } t_step;

    // configuration
    logic [30:0]        r_q;
    logic [30:0]        r_r;
    logic signed [31:0] r_a;
    logic signed [31:0] r_h;
    logic signed [31:0] r_init_x;
    logic [30:0]        r_init_p;

    // filter state and working registers
    t_state             r_state;
    t_step              r_step;
    logic signed [31:0] r_x;
    logic [30:0]        r_p;
    logic signed [31:0] r_k;
    logic signed [31:0] r_x1;
    logic [30:0]        r_p1;
    logic [30:0]        r_s;
    logic signed [31:0] r_t;
    logic signed [31:0] r_t2;
    logic signed [31:0] r_z;
    logic signed [63:0] r_prod;
    logic               r_sat;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               cfg_wr;
    logic               accept;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [FX_W-1:0] fx_full;
    logic               fx_ovf;
    logic signed [31:0] fx_sat;
    logic signed [32:0] post_add;
    logic               post_sub;
    logic               post_is_var;
    logic signed [33:0] add_ext;
    logic signed [33:0] fx_ext;
    logic signed [33:0] sum;
    logic               sum_ovf;
    logic signed [31:0] sum_sat;
    logic signed [31:0] post_val;
    logic               post_clip;
    logic               div_start;
    t_div_res           div_res;

    // ------------------------------------------------------------ apb
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q      <= '0;
            r_r      <= ONE_VAR;
            r_a      <= ONE_FX;
            r_h      <= ONE_FX;
            r_init_x <= '0;
            r_init_p <= ONE_VAR;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_PROCESS_NOISE: r_q      <= pwdata[30:0];
                REG_MEASURE_NOISE: r_r      <= pwdata[30:0];
                REG_STATE_GAIN:    r_a      <= $signed(pwdata);
                REG_OBSERVE_GAIN:  r_h      <= $signed(pwdata);
                REG_INIT_ESTIMATE: r_init_x <= $signed(pwdata);
                REG_INIT_VARIANCE: r_init_p <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_PROCESS_NOISE: prdata = {1'b0, r_q};
            REG_MEASURE_NOISE: prdata = {1'b0, r_r};
            REG_STATE_GAIN:    prdata = r_a;
            REG_OBSERVE_GAIN:  prdata = r_h;
            REG_INIT_ESTIMATE: prdata = r_init_x;
            REG_INIT_VARIANCE: prdata = {1'b0, r_init_p};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------ operand select
    always_comb begin
        unique case (r_step)
            ST_X1:    begin mul_a = r_a;  mul_b = r_x;                     end
            ST_AP:    begin mul_a = r_a;  mul_b = $signed({1'b0, r_p});    end
            ST_P1:    begin mul_a = r_t;  mul_b = r_a;                     end
            ST_HP:    begin mul_a = r_h;  mul_b = $signed({1'b0, r_p1});   end
            ST_S:     begin mul_a = r_t;  mul_b = r_h;                     end
            ST_PH:    begin mul_a = $signed({1'b0, r_p1}); mul_b = r_h;    end
            ST_INNOV: begin mul_a = r_h;  mul_b = r_x1;                    end
            ST_XN:    begin mul_a = r_k;  mul_b = r_t;                     end
            ST_C:     begin mul_a = r_k;  mul_b = r_h;                     end
            ST_CC:    begin mul_a = r_t;  mul_b = r_t;                     end
            ST_T1:    begin mul_a = r_t;  mul_b = $signed({1'b0, r_p1});   end
            ST_KK:    begin mul_a = r_k;  mul_b = r_k;                     end
            ST_T2:    begin mul_a = r_t;  mul_b = $signed({1'b0, r_r});    end
            default:  begin mul_a = '0;   mul_b = '0;                      end
        endcase
    end

    // ------------------------------------------------------------ product post step
    // upper bits of the product are the floor of the fraction shift
    assign fx_full = r_prod[63:FRAC_BITS];
    assign fx_ovf  = !((&fx_full[FX_W-1:31]) | ~(|fx_full[FX_W-1:31]));
    assign fx_sat  = fx_ovf ? (fx_full[FX_W-1] ? S32_MIN : S32_MAX) : fx_full[31:0];

    always_comb begin
        post_add    = '0;
        post_sub    = 1'b0;
        post_is_var = 1'b0;
        unique case (r_step)
            ST_P1:    begin post_add = $signed({2'b00, r_q}); post_is_var = 1'b1; end
            ST_S:     begin post_add = $signed({2'b00, r_r}); post_is_var = 1'b1; end
            ST_INNOV: begin post_add = 33'(r_z);   post_sub = 1'b1;               end
            ST_XN:    begin post_add = 33'(r_x1);                                 end
            ST_C:     begin post_add = 33'(ONE_FX); post_sub = 1'b1;              end
            ST_T2:    begin post_add = 33'(r_t2);  post_is_var = 1'b1;            end
            default: ;
        endcase
    end

    assign add_ext  = 34'(post_add);
    assign fx_ext   = 34'(fx_sat);
    assign sum      = post_sub ? (add_ext - fx_ext) : (add_ext + fx_ext);
    assign sum_ovf  = !((&sum[33:31]) | ~(|sum[33:31]));
    assign sum_sat  = sum_ovf ? (sum[33] ? S32_MIN : S32_MAX) : sum[31:0];
    // variances never go below zero, and that clamp is not flagged
    assign post_val  = (post_is_var && sum_sat[31]) ? '0 : sum_sat;
    assign post_clip = fx_ovf | sum_ovf;

    // ------------------------------------------------------------ divider
    assign div_start = (r_state == S_DIV_GO);

    skf_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   (r_s),
        .o_res   (div_res)
    );

    // ------------------------------------------------------------ sequencer
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_X1;
            r_x         <= '0;
            r_p         <= ONE_VAR;
            r_k         <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the finish step loads the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sat <= 1'b0;
                        if (i_in_data.op == OP_REINIT) begin
                            r_x1    <= r_init_x;
                            r_p1    <= r_init_p;
                            r_k     <= '0;
                            r_state <= S_FINISH;
                        end else begin
                            r_z     <= i_in_data.measurement;
                            r_step  <= ST_X1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= 64'(mul_a) * 64'(mul_b);
                    r_state <= (r_step == ST_PH) ? S_DIV_GO : S_POST;
                end
                S_POST: begin
                    r_sat <= r_sat | post_clip;
                    unique case (r_step)
                        ST_X1, ST_XN:                 r_x1 <= post_val;
                        ST_P1, ST_T2:                 r_p1 <= post_val[30:0];
                        ST_S:                         r_s  <= post_val[30:0];
                        ST_T1:                        r_t2 <= post_val;
                        default:                      r_t  <= post_val;
                    endcase
                    if (r_step == ST_S && post_val == '0) begin
                        // no information in the measurement: keep the prediction
                        r_k     <= '0;
                        r_state <= S_FINISH;
                    end else if (r_step == ST_T2) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_step  <= t_step'(r_step + 4'd1);
                        r_state <= S_MUL;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_res.done) begin
                        r_k     <= div_res.quot;
                        r_sat   <= r_sat | div_res.clip;
                        r_step  <= ST_INNOV;
                        r_state <= S_MUL;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.estimate  <= r_x1;
                        r_out.gain      <= r_k;
                        r_out.saturated <= r_sat;
                        r_out_valid     <= 1'b1;
                        r_x             <= r_x1;
                        r_p             <= r_p1;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: design/skf_checker.sv
// port-level checks of the scalar kalman filter core, bound to the top level
// depends on skf_pkg and scalar_kalman_filter_core_assert.svh
`include "scalar_kalman_filter_core_assert.svh"
`default_nettype none

module skf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input skf_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input skf_pkg::t_out_item o_out_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [4:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);
    import skf_pkg::*;

    // a stalled result holds
    `SKF_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result changed while stalled")

    // one request in flight: busy right after acceptance
    `SKF_ASSERT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "ready stayed high after a request")

    // a new result only ever follows a busy cycle
    `SKF_ASSERT(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(!o_in_ready), "result appeared without work")

    // reset empties the output register
    `SKF_ASSERT_ALWAYS(a_rst_out_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind scalar_kalman_filter_core skf_checker u_skf_checker (.*);

`default_nettype wire

FILE: tb/sv/scalar_kalman_filter_core_checker.sv
// checker for the scalar kalman filter core: follows the apb writes, predicts each
// request's result in Q16.16 and compares the results as they leave the core
// depends on skf_pkg
`timescale 1ns / 1ps

module scalar_kalman_filter_core_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  skf_pkg::t_in_item  i_req,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  skf_pkg::t_out_item i_res,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [4:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_mismatches,
    output int                 o_results_due
);

    import skf_pkg::*;

    localparam longint ONE       = longint'(1) << FRAC_BITS;
    localparam longint S32_HI    = longint'(S32_MAX);
    localparam longint S32_LO    = longint'(S32_MIN);
    localparam int     MAX_LINES = 100;

    // filter registers as the core should hold them
    longint q_noise, r_noise, a_gain, h_gain, x_init, p_init;
    longint x_est, p_var, k_gain;
    logic   clipped;

    t_out_item filter_results_due[$];

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        o_mismatches++;
        if (o_mismatches <= MAX_LINES) begin
            $display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
        end
    endtask

    function automatic longint clip32(longint v);
        if (v > S32_HI) begin
            clipped = 1'b1;
            return S32_HI;
        end
        if (v < S32_LO) begin
            clipped = 1'b1;
            return S32_LO;
        end
        return v;
    endfunction

    // variances stay in [0, 2^31-1]; only the top clip raises the flag
    function automatic longint clip_var(longint v);
        if (v < 0) return 0;
        if (v > S32_HI) begin
            clipped = 1'b1;
            return S32_HI;
        end
        return v;
    endfunction

    // exact product, floored shift, then saturated
    function automatic longint fx_mul(longint a, longint b);
        return clip32((a * b) >>> FRAC_BITS);
    endfunction

    // (num << frac) / den truncated toward zero, den positive
    function automatic longint fx_div(longint num, longint den);
        logic        neg;
        logic [95:0] mag, quo, lim;
        neg = num < 0;
        mag = neg ? 96'(-num) : 96'(num);
        quo = (mag << FRAC_BITS) / 96'(den);
        lim = neg ? 96'h8000_0000 : 96'h7fff_ffff;
        if (quo > lim) begin
            clipped = 1'b1;
            return neg ? S32_LO : S32_HI;
        end
        return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function automatic t_out_item kalman_step(t_in_item req);
        t_out_item res;
        longint    z, x1, p1, s, k, innov, c, t1, t2;
        clipped = 1'b0;
        if (req.op == OP_REINIT) begin
            x_est  = x_init;
            p_var  = p_init;
            k_gain = 0;
        end else begin
            z  = longint'($signed(req.measurement));
            x1 = fx_mul(a_gain, x_est);
            p1 = clip_var(clip32(fx_mul(fx_mul(a_gain, p_var), a_gain) + q_noise));
            s  = clip_var(clip32(fx_mul(fx_mul(h_gain, p1), h_gain) + r_noise));
            if (s == 0) begin
                // no innovation variance: keep the prediction
                k_gain = 0;
                x_est  = x1;
                p_var  = p1;
            end else begin
                k      = fx_div(p1 * h_gain, s);
                innov  = clip32(z - fx_mul(h_gain, x1));
                x_est  = clip32(x1 + fx_mul(k, innov));
                // joseph form: (1 - kh)^2 p + k^2 r
                c      = clip32(ONE - fx_mul(k, h_gain));
                t1     = fx_mul(fx_mul(c, c), p1);
                t2     = fx_mul(fx_mul(k, k), r_noise);
                p_var  = clip_var(clip32(t1 + t2));
                k_gain = k;
            end
        end
        res.estimate  = x_est[31:0];
        res.gain      = k_gain[31:0];
        res.saturated = clipped;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            q_noise = 0;
            r_noise = ONE;
            a_gain  = ONE;
            h_gain  = ONE;
            x_init  = 0;
            p_init  = ONE;
            x_est   = 0;
            p_var   = ONE;
            k_gain  = 0;
            filter_results_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (filter_results_due.size() == 0) begin
                    report_mismatch("unrequested result", i_res.estimate, 32'h0);
                end else begin
                    want = filter_results_due.pop_front();
                    if (i_res.estimate !== want.estimate)
                        report_mismatch("estimate", i_res.estimate, want.estimate);
                    if (i_res.gain !== want.gain)
                        report_mismatch("gain", i_res.gain, want.gain);
                    if (i_res.saturated !== want.saturated)
                        report_mismatch("saturated", 32'(i_res.saturated),
                                        32'(want.saturated));
                end
            end
            if (i_req_valid && i_req_ready) begin
                filter_results_due.push_back(kalman_step(i_req));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_PROCESS_NOISE: q_noise = longint'(i_pwdata[30:0]);
                    REG_MEASURE_NOISE: r_noise = longint'(i_pwdata[30:0]);
                    REG_STATE_GAIN:    a_gain  = longint'($signed(i_pwdata));
                    REG_OBSERVE_GAIN:  h_gain  = longint'($signed(i_pwdata));
                    REG_INIT_ESTIMATE: x_init  = longint'($signed(i_pwdata));
                    REG_INIT_VARIANCE: p_init  = longint'(i_pwdata[30:0]);
                    default: ;
                endcase
            end
        end
        o_results_due = filter_results_due.size();
    end

endmodule

FILE: tb/sv/scalar_kalman_filter_core_tb.sv
// top of the scalar kalman filter core testbench: clock, reset, apb set-up,
// request and result traffic; depends on skf_pkg, the core and its checker
`timescale 1ns / 1ps

module scalar_kalman_filter_core_tb;

    import skf_pkg::*;

    localparam int          FRAC_BITS       = 16;
    localparam int unsigned ONE             = 1 << FRAC_BITS;
    localparam logic [31:0] U31_TOP         = 32'h7fff_ffff;
    localparam logic [2:0]  REG_UNUSED_LO   = 3'd6;
    localparam logic [2:0]  REG_UNUSED_HI   = 3'd7;
    localparam int          RAND_PHASES     = 14;
    localparam int          ITEMS_PER_PHASE = 75;
    localparam int          HOLD_PHASE      = 3;
    localparam int          HOLD_CYCLES     = 500;
    localparam int          CYCLE_LIMIT     = 400000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    t_in_item    req       = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    t_out_item   res;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [4:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int results_due;
    int cycle_count   = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    bit idle_on       = 1'b1;

    scalar_kalman_filter_core #(.FRAC_BITS(FRAC_BITS)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    scalar_kalman_filter_core_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req         (req),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_res         (res),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_results_due (results_due)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[scalar_kalman_filter_core] ERROR");
            $finish;
        end
    end

    // result side: random back-pressure, plus long hold-offs on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_requests != holds_done) begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            res_ready <= !(idle_on && $urandom_range(99) < 17);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic close_bus();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_setting(input logic [31:0] q, input logic [31:0] r,
                                 input logic [31:0] a, input logic [31:0] h,
                                 input logic [31:0] x0, input logic [31:0] p0);
        write_reg(REG_PROCESS_NOISE, q);
        write_reg(REG_MEASURE_NOISE, r);
        write_reg(REG_STATE_GAIN, a);
        write_reg(REG_OBSERVE_GAIN, h);
        write_reg(REG_INIT_ESTIMATE, x0);
        write_reg(REG_INIT_VARIANCE, p0);
        close_bus();
    endtask

    task automatic send_request(input logic op, input logic [31:0] z);
        if (idle_on && $urandom_range(99) < 17) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= {op, z};
        do @(posedge clk); while (!req_ready);
    endtask

    // stop offering and let every outstanding result come back
    task automatic finish_requests();
        req_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_setting(logic [2:0] idx);
        int unsigned mode;
        logic [31:0] v;
        logic        narrow;
        mode   = $urandom_range(9);
        narrow = idx inside {REG_PROCESS_NOISE, REG_MEASURE_NOISE, REG_INIT_VARIANCE};
        if (mode == 0) begin
            case ($urandom_range(2))
                0:       v = '0;
                1:       v = narrow ? U31_TOP : S32_MAX;
                default: v = narrow ? 32'd1 : S32_MIN;
            endcase
        end else if (mode == 1) begin
            v = $urandom;
            if (narrow) v[31] = 1'b0;
        end else begin
            case (idx)
                REG_PROCESS_NOISE: v = $urandom_range(ONE / 4, 0);
                REG_MEASURE_NOISE: v = $urandom_range(4 * ONE, 0);
                REG_STATE_GAIN: begin
                    v = $urandom_range(ONE + ONE / 4, ONE / 2);
                    if ($urandom_range(9) == 0) v = -v;
                end
                REG_OBSERVE_GAIN: begin
                    v = $urandom_range(3 * ONE, ONE / 4);
                    if ($urandom_range(3) == 0) v = -v;
                end
                REG_INIT_ESTIMATE: begin
                    v = $urandom_range(64 * ONE, 0);
                    if ($urandom_range(1) == 0) v = -v;
                end
                default: v = $urandom_range(16 * ONE, 0);
            endcase
        end
        return v;
    endfunction

    function automatic logic [31:0] pick_measurement();
        logic [31:0] z;
        if ($urandom_range(9) < 4) begin
            z = $urandom;
        end else begin
            z = $urandom_range(32 * ONE, 0);
            if ($urandom_range(1) == 0) z = -z;
        end
        return z;
    endfunction

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unit gains, zero process noise and unit measurement noise
        send_request(OP_SAMPLE, 32'h0);
        send_request(OP_SAMPLE, S32_MAX);
        send_request(OP_SAMPLE, S32_MIN);
        send_request(OP_SAMPLE, 32'h1);
        send_request(OP_SAMPLE, 32'hffff_ffff);
        send_request(OP_REINIT, S32_MAX);
        finish_requests();

        // writes past the last register must change nothing
        write_reg(REG_UNUSED_LO, 32'h5a5a_a5a5);
        write_reg(REG_UNUSED_HI, 32'hffff_ffff);
        close_bus();
        send_request(OP_SAMPLE, 3 * ONE);
        finish_requests();

        // zero observation and zero noise: innovation variance is zero
        write_setting(32'h0, 32'h0, ONE, 32'h0, -(5 * ONE), 32'h0);
        send_request(OP_REINIT, 32'h0);
        send_request(OP_SAMPLE, 7 * ONE);
        send_request(OP_SAMPLE, S32_MIN);
        finish_requests();

        // everything at full scale
        write_setting(U31_TOP, U31_TOP, S32_MAX, S32_MIN, S32_MAX, U31_TOP);
        send_request(OP_REINIT, 32'h0);
        send_request(OP_SAMPLE, S32_MIN);
        send_request(OP_SAMPLE, S32_MAX);
        send_request(OP_SAMPLE, 32'h0);
        finish_requests();

        // tiny observation gain with huge variance: gain overflows
        write_setting(32'h0, 32'h1, ONE, 32'h1, S32_MIN, U31_TOP);
        send_request(OP_REINIT, 32'h0);
        send_request(OP_SAMPLE, S32_MAX);
        send_request(OP_SAMPLE, 32'h0);
        finish_requests();

        // negative gains
        write_setting(32'h0, 32'h0, -(ONE / 2), -(3 * ONE), 9 * ONE, 2 * ONE);
        send_request(OP_REINIT, 32'h0);
        send_request(OP_SAMPLE, -ONE);
        send_request(OP_SAMPLE, ONE);
        send_request(OP_SAMPLE, S32_MIN);
        finish_requests();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            // first random phase runs flat out on both sides
            idle_on = (ph != 0);
            write_setting(pick_setting(REG_PROCESS_NOISE), pick_setting(REG_MEASURE_NOISE),
                          pick_setting(REG_STATE_GAIN), pick_setting(REG_OBSERVE_GAIN),
                          pick_setting(REG_INIT_ESTIMATE), pick_setting(REG_INIT_VARIANCE));
            if (ph == HOLD_PHASE) hold_requests++;
            if ($urandom_range(9) < 7) send_request(OP_REINIT, $urandom);
            repeat (ITEMS_PER_PHASE) begin
                send_request(($urandom_range(99) < 6) ? OP_REINIT : OP_SAMPLE,
                             pick_measurement());
            end
            finish_requests();
        end

        repeat (16) @(posedge clk);
        if (mismatches == 0) begin
            $display("[scalar_kalman_filter_core] OK");
        end else begin
            $display("[scalar_kalman_filter_core] ERROR");
        end
        $finish;
    end

endmodule
